// File: sv/sliding_window_arq_sender_core_macros.svh
// Assertion macros for the sliding window ARQ sender core.
`ifndef SLIDING_WINDOW_ARQ_SENDER_CORE_MACROS_SVH
`define SLIDING_WINDOW_ARQ_SENDER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SWARQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swarq: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SWARQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swarq: next-cycle check failed");

`endif

// File: sv/swarq_pkg.sv
// Shared constants and types for the sliding window ARQ sender core.
package swarq_pkg;

    localparam int WINDOW    = 16;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int OFF_W     = 32;
    localparam int BYTES_W   = 11;
    localparam int LIMIT_W   = 5;
    localparam int DUP_W     = 2;
    localparam int FUNC_W    = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CHUNK_MAX = 1024;
    localparam int DUP_ARM   = 2;
    localparam int MAX_OUT   = 16;
    localparam int SEND_LIMIT_RST = 8;

    localparam int S_TDATA_W = ((BYTES_W + OFF_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = SLOT_W + 2 * OFF_W + 2;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int SEG_W     = 2 * OFF_W;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SEND_LIMIT   = CFG_IDX_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FN_CHUNK = 2'd0,
        FN_ACK   = 2'd1,
        FN_TICK  = 2'd2,
        FN_SEND  = 2'd3
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_NEW     = 2'd1,
        KIND_FAST    = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

endpackage

// File: sv/sliding_window_arq_sender_core.sv
// Go-back-N ARQ sender window controller with fast retransmit (top level).
// An advancing ack slides the window slot by slot; a tick may emit a beat per outstanding segment.
// Takes one event at a time; not ready while an event is in work.
// Reset: async active low; pointers, counters, flags cleared, send_limit 8; slot RAM not cleared.
`include "sliding_window_arq_sender_core_macros.svh"

module sliding_window_arq_sender_core
    import swarq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFF_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // chunk_bytes, ack_offset, zero pad
    input  logic [FUNC_W-1:0]     s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // slot, seg_start, seg_end, accepted, done_res, pad
    output logic [KIND_W-1:0]     m_tuser,   // kind
    output logic                  m_tlast
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_EXEC      = 11'b000_0000_0010,
        ST_ACK_CMP   = 11'b000_0000_0100,
        ST_SLIDE_RD  = 11'b000_0000_1000,
        ST_SLIDE_CHK = 11'b000_0001_0000,
        ST_TICK_RD   = 11'b000_0010_0000,
        ST_TICK_CHK  = 11'b000_0100_0000,
        ST_RD_WAIT   = 11'b000_1000_0000,
        ST_SEND_OUT  = 11'b001_0000_0000,
        ST_RES_OUT   = 11'b010_0000_0000,
        ST_EMIT_ZERO = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [OFF_W-1:0]     total_reg, total_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [SLOT_W-1:0]    base_reg, base_next;
    logic [SLOT_W-1:0]    next_send_reg, next_send_next;
    logic [SLOT_W-1:0]    fill_reg, fill_next;
    logic [SLOT_W-1:0]    walk_reg, walk_next;
    logic [CNT_W-1:0]     occupancy_reg, occupancy_next;
    logic [CNT_W-1:0]     in_flight_reg, in_flight_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [OFF_W-1:0]     running_reg, running_next;
    logic [OFF_W-1:0]     last_ack_reg, last_ack_next;
    logic [OFF_W-1:0]     tick_mark_reg, tick_mark_next;
    logic [DUP_W-1:0]     dup_reg, dup_next;
    logic                 fast_reg, fast_next;
    logic                 finished_reg, finished_next;
    kind_t                send_kind_reg, send_kind_next;
    logic                 out_valid_reg;

    func_t                func_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    logic [OFF_W-1:0]     ack_reg;

    kind_t                out_kind_reg, out_kind;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot;
    logic [OFF_W-1:0]     out_start_reg, out_start;
    logic [OFF_W-1:0]     out_end_reg, out_end;
    logic                 out_last_reg, out_last;
    logic                 out_acc_reg, out_acc;
    logic                 out_done_reg, out_done;
    logic                 out_load;
    logic                 out_free;

    logic                 ram_we;
    logic [SEG_W-1:0]     ram_rdata;
    logic [OFF_W-1:0]     rd_start;
    logic [OFF_W-1:0]     rd_end;

    logic [OFF_W-1:0]     op_a;
    logic [OFF_W-1:0]     op_b;
    logic                 op_sub;
    logic [OFF_W:0]       alu_sum;
    logic                 cmp_lt;
    logic                 cmp_eq;
    logic [OFF_W-1:0]     add_sat;

    logic [BYTES_W-1:0]   bytes_clamp;
    logic [LIMIT_W-1:0]   lim;
    logic [OFF_W-1:0]     tick_now;

    swarq_ram #(
        .WIDTH (SEG_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg),
        .wdata ({add_sat, running_reg}),
        .raddr (walk_reg),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[OFF_W-1:0];
    assign rd_end   = ram_rdata[SEG_W-1:OFF_W];

    // shared adder: add with saturation, or subtract for compare
    always_comb
    begin
        alu_sum = {1'b0, op_a} + (op_sub ? {1'b0, ~op_b} : {1'b0, op_b})
                  + {{OFF_W{1'b0}}, op_sub};
        cmp_lt  = op_sub & ~alu_sum[OFF_W];
        cmp_eq  = (op_a == op_b);
        add_sat = alu_sum[OFF_W] ? {OFF_W{1'b1}} : alu_sum[OFF_W-1:0];
    end

    assign bytes_clamp = (bytes_reg > BYTES_W'(CHUNK_MAX)) ? BYTES_W'(CHUNK_MAX) : bytes_reg;
    assign lim         = (limit_reg > LIMIT_W'(MAX_OUT)) ? LIMIT_W'(MAX_OUT) : limit_reg;
    assign tick_now    = (occupancy_reg != '0) ? rd_end : running_reg;
    assign out_free    = ~out_valid_reg | m_tready;
    assign s_tready    = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        limit_next     = limit_reg;
        base_next      = base_reg;
        next_send_next = next_send_reg;
        fill_next      = fill_reg;
        walk_next      = walk_reg;
        occupancy_next = occupancy_reg;
        in_flight_next = in_flight_reg;
        cnt_next       = cnt_reg;
        running_next   = running_reg;
        last_ack_next  = last_ack_reg;
        tick_mark_next = tick_mark_reg;
        dup_next       = dup_reg;
        fast_next      = fast_reg;
        finished_next  = finished_reg;
        send_kind_next = send_kind_reg;
        ram_we         = 1'b0;
        out_load       = 1'b0;
        out_kind       = KIND_NONE;
        out_slot       = '0;
        out_start      = '0;
        out_end        = '0;
        out_last       = 1'b1;
        out_acc        = 1'b0;
        out_done       = finished_reg;
        op_a           = ack_reg;
        op_b           = total_reg;
        op_sub         = 1'b1;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOTAL_LENGTH: total_next = cfg_data;
                REG_SEND_LIMIT:   limit_next = cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (finished_reg)
                begin
                    state_next = ST_EMIT_ZERO;
                end
                else
                begin
                    case (func_reg)
                        FN_CHUNK:
                        begin
                            if (occupancy_reg == CNT_W'(WINDOW))
                            begin
                                state_next = ST_EMIT_ZERO;
                            end
                            else
                            begin
                                op_a   = running_reg;
                                op_b   = {{(OFF_W-BYTES_W){1'b0}}, bytes_clamp};
                                op_sub = 1'b0;
                                if (out_free)
                                begin
                                    ram_we         = 1'b1;
                                    running_next   = add_sat;
                                    fill_next      = SLOT_W'(fill_reg + 1'b1);
                                    occupancy_next = CNT_W'(occupancy_reg + 1'b1);
                                    out_load       = 1'b1;
                                    out_slot       = fill_reg;
                                    out_start      = running_reg;
                                    out_end        = add_sat;
                                    out_acc        = 1'b1;
                                    state_next     = ST_IDLE;
                                end
                            end
                        end
                        FN_ACK:
                        begin
                            if (!cmp_lt)
                            begin
                                finished_next = 1'b1;
                                state_next    = ST_EMIT_ZERO;
                            end
                            else
                            begin
                                state_next = ST_ACK_CMP;
                            end
                        end
                        FN_TICK:
                        begin
                            walk_next  = base_reg;
                            state_next = ST_TICK_RD;
                        end
                        FN_SEND:
                        begin
                            fast_next = 1'b0;
                            if (fast_reg && in_flight_reg != '0)
                            begin
                                send_kind_next = KIND_FAST;
                                walk_next      = base_reg;
                                state_next     = ST_RD_WAIT;
                            end
                            else if ((in_flight_reg < CNT_W'(lim))
                                     && (in_flight_reg < occupancy_reg))
                            begin
                                send_kind_next = KIND_NEW;
                                walk_next      = next_send_reg;
                                state_next     = ST_RD_WAIT;
                            end
                            else
                            begin
                                state_next = ST_EMIT_ZERO;
                            end
                        end
                        default: state_next = ST_EMIT_ZERO;
                    endcase
                end
            end
            ST_ACK_CMP:
            begin
                op_b = last_ack_reg;
                if (cmp_eq)
                begin
                    if (DUP_W'(dup_reg + 1'b1) >= DUP_W'(DUP_ARM))
                    begin
                        dup_next  = '0;
                        fast_next = 1'b1;
                    end
                    else
                    begin
                        dup_next = DUP_W'(dup_reg + 1'b1);
                    end
                    state_next = ST_EMIT_ZERO;
                end
                else if (cmp_lt)
                begin
                    state_next = ST_EMIT_ZERO;
                end
                else
                begin
                    dup_next      = DUP_W'(1);
                    last_ack_next = ack_reg;
                    walk_next     = base_reg;
                    state_next    = ST_SLIDE_RD;
                end
            end
            ST_SLIDE_RD:
            begin
                state_next = (in_flight_reg == '0) ? ST_EMIT_ZERO : ST_SLIDE_CHK;
            end
            ST_SLIDE_CHK:
            begin
                op_b = rd_end;
                if (cmp_lt)
                begin
                    state_next = ST_EMIT_ZERO;
                end
                else
                begin
                    base_next      = SLOT_W'(base_reg + 1'b1);
                    walk_next      = SLOT_W'(base_reg + 1'b1);
                    occupancy_next = CNT_W'(occupancy_reg - 1'b1);
                    in_flight_next = CNT_W'(in_flight_reg - 1'b1);
                    state_next     = ST_SLIDE_RD;
                end
            end
            ST_TICK_RD:
            begin
                state_next = ST_TICK_CHK;
            end
            ST_TICK_CHK:
            begin
                op_a           = tick_now;
                op_b           = tick_mark_reg;
                tick_mark_next = tick_now;
                if (cmp_eq && in_flight_reg != '0)
                begin
                    cnt_next   = '0;
                    state_next = ST_RES_OUT;
                end
                else
                begin
                    state_next = ST_EMIT_ZERO;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = (func_reg == FN_SEND) ? ST_SEND_OUT : ST_RES_OUT;
            end
            ST_SEND_OUT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_kind  = send_kind_reg;
                    out_slot  = walk_reg;
                    out_start = rd_start;
                    out_end   = rd_end;
                    if (send_kind_reg == KIND_NEW)
                    begin
                        next_send_next = SLOT_W'(next_send_reg + 1'b1);
                        in_flight_next = CNT_W'(in_flight_reg + 1'b1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RES_OUT:
            begin
                out_last = (CNT_W'(cnt_reg + 1'b1) == in_flight_reg);
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_TIMEOUT;
                    out_slot   = walk_reg;
                    out_start  = rd_start;
                    out_end    = rd_end;
                    cnt_next   = CNT_W'(cnt_reg + 1'b1);
                    walk_next  = SLOT_W'(walk_reg + 1'b1);
                    state_next = out_last ? ST_IDLE : ST_RD_WAIT;
                end
            end
            ST_EMIT_ZERO:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            limit_reg     <= LIMIT_W'(SEND_LIMIT_RST);
            base_reg      <= '0;
            next_send_reg <= '0;
            fill_reg      <= '0;
            walk_reg      <= '0;
            occupancy_reg <= '0;
            in_flight_reg <= '0;
            cnt_reg       <= '0;
            running_reg   <= '0;
            last_ack_reg  <= '0;
            tick_mark_reg <= '0;
            dup_reg       <= '0;
            fast_reg      <= 1'b0;
            finished_reg  <= 1'b0;
            send_kind_reg <= KIND_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            limit_reg     <= limit_next;
            base_reg      <= base_next;
            next_send_reg <= next_send_next;
            fill_reg      <= fill_next;
            walk_reg      <= walk_next;
            occupancy_reg <= occupancy_next;
            in_flight_reg <= in_flight_next;
            cnt_reg       <= cnt_next;
            running_reg   <= running_next;
            last_ack_reg  <= last_ack_next;
            tick_mark_reg <= tick_mark_next;
            dup_reg       <= dup_next;
            fast_reg      <= fast_next;
            finished_reg  <= finished_next;
            send_kind_reg <= send_kind_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg  <= func_t'(s_tuser);
            bytes_reg <= s_tdata[BYTES_W-1:0];
            ack_reg   <= s_tdata[BYTES_W +: OFF_W];
        end
        if (out_load)
        begin
            out_kind_reg  <= out_kind;
            out_slot_reg  <= out_slot;
            out_start_reg <= out_start;
            out_end_reg   <= out_end;
            out_last_reg  <= out_last;
            out_acc_reg   <= out_acc;
            out_done_reg  <= out_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, out_done_reg, out_acc_reg,
                       out_end_reg, out_start_reg, out_slot_reg};

    `SWARQ_ASSERT_SAME(a_inflight_le_occ, 1'b1, in_flight_reg <= occupancy_reg)
    `SWARQ_ASSERT_SAME(a_no_store_when_full, ram_we, occupancy_reg != CNT_W'(WINDOW))
    `SWARQ_ASSERT_NEXT(a_finished_sticky, finished_reg, finished_reg)
    `SWARQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

// File: sv/swarq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swarq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: verif/arq_window_checker.sv
`timescale 1ns / 1ps
// Checker for the ARQ sender core: mirrors the send window and compares every output beat.
module arq_window_checker
    import swarq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OFF_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // chunk_bytes, ack_offset, zero pad
    input  logic [FUNC_W-1:0]    s_tuser,   // func
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // slot, seg_start, seg_end, accepted, done_res, pad
    input  logic [KIND_W-1:0]    m_tuser,   // kind
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending
);

    localparam int START_LSB = SLOT_W;
    localparam int END_LSB   = SLOT_W + OFF_W;
    localparam int ACC_BIT   = SLOT_W + 2 * OFF_W;
    localparam int DONE_BIT  = ACC_BIT + 1;

    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [OFF_W-1:0]   seg_start;
        logic [OFF_W-1:0]   seg_end;
        logic               last;
        logic               accepted;
        logic               done_res;
    } seg_beat_t;

    seg_beat_t          expected_segs[$];
    logic [OFF_W-1:0]   seg_lo [WINDOW];
    logic [OFF_W-1:0]   seg_hi [WINDOW];
    logic [SLOT_W-1:0]  base_q;
    logic [SLOT_W-1:0]  send_q;
    logic [SLOT_W-1:0]  fill_q;
    logic [CNT_W-1:0]   held;
    logic [CNT_W-1:0]   in_air;
    logic [OFF_W-1:0]   stream_off;
    logic [OFF_W-1:0]   acked;
    logic [OFF_W-1:0]   tick_ref;
    logic [OFF_W-1:0]   total_len;
    logic [LIMIT_W-1:0] limit;
    logic [DUP_W-1:0]   dups;
    logic               fast_armed;
    logic               all_acked;

    function automatic void queue_beat(kind_t k, logic [SLOT_W-1:0] sl, logic [OFF_W-1:0] lo,
                                       logic [OFF_W-1:0] hi, logic acc, logic lst);
        seg_beat_t b;
        b.kind      = k;
        b.slot      = sl;
        b.seg_start = lo;
        b.seg_end   = hi;
        b.last      = lst;
        b.accepted  = acc;
        b.done_res  = all_acked;
        expected_segs.push_back(b);
    endfunction

    task automatic advance_window(func_t fn, logic [BYTES_W-1:0] nbytes, logic [OFF_W-1:0] ack);
        logic [OFF_W:0]    sum;
        logic [OFF_W-1:0]  now;
        logic [SLOT_W-1:0] s;
        logic [CNT_W-1:0]  lim;
        int                n;
        if (all_acked) begin
            queue_beat(KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
            return;
        end
        case (fn)
            FN_CHUNK: begin
                if (held < WINDOW) begin
                    if (nbytes > CHUNK_MAX)
                        nbytes = BYTES_W'(CHUNK_MAX);
                    sum = {1'b0, stream_off} + nbytes;
                    seg_lo[fill_q] = stream_off;
                    seg_hi[fill_q] = sum[OFF_W] ? '1 : sum[OFF_W-1:0];
                    queue_beat(KIND_NONE, fill_q, seg_lo[fill_q], seg_hi[fill_q], 1'b1, 1'b1);
                    stream_off = seg_hi[fill_q];
                    fill_q++;
                    held++;
                end
                else
                    queue_beat(KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
            end
            FN_ACK: begin
                if (ack >= total_len)
                    all_acked = 1'b1;
                else if (ack == acked) begin
                    dups++;
                    if (dups >= DUP_ARM) begin
                        dups = '0;
                        fast_armed = 1'b1;
                    end
                end
                else if (ack > acked) begin
                    dups = DUP_W'(1);
                    acked = ack;
                    while (in_air > 0 && seg_hi[base_q] <= ack) begin
                        base_q++;
                        held--;
                        in_air--;
                    end
                end
                queue_beat(KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
            end
            FN_TICK: begin
                now = (held > 0) ? seg_hi[base_q] : stream_off;
                n = 0;
                if (now == tick_ref && in_air > 0) begin
                    s = base_q;
                    for (n = 0; n < in_air; n++) begin
                        queue_beat(KIND_TIMEOUT, s, seg_lo[s], seg_hi[s], 1'b0, n == in_air - 1);
                        s++;
                    end
                end
                tick_ref = now;
                if (n == 0)
                    queue_beat(KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
            end
            default: begin
                lim = (limit > MAX_OUT) ? CNT_W'(MAX_OUT) : CNT_W'(limit);
                if (fast_armed && in_air > 0) begin
                    fast_armed = 1'b0;
                    queue_beat(KIND_FAST, base_q, seg_lo[base_q], seg_hi[base_q], 1'b0, 1'b1);
                end
                else begin
                    fast_armed = 1'b0;
                    if (in_air < lim && in_air < held) begin
                        queue_beat(KIND_NEW, send_q, seg_lo[send_q], seg_hi[send_q], 1'b0, 1'b1);
                        send_q++;
                        in_air++;
                    end
                    else
                        queue_beat(KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        seg_beat_t got;
        seg_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                seg_lo[i] = '0;
                seg_hi[i] = '0;
            end
            base_q     = '0;
            send_q     = '0;
            fill_q     = '0;
            held       = '0;
            in_air     = '0;
            stream_off = '0;
            acked      = '0;
            tick_ref   = '0;
            total_len  = '0;
            limit      = LIMIT_W'(SEND_LIMIT_RST);
            dups       = '0;
            fast_armed = 1'b0;
            all_acked  = 1'b0;
            fail_count = 0;
            expected_segs.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOTAL_LENGTH: total_len = cfg_data;
                    REG_SEND_LIMIT:   limit = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_window(func_t'(s_tuser), s_tdata[BYTES_W-1:0], s_tdata[BYTES_W +: OFF_W]);
            if (m_tvalid && m_tready)
            begin
                got.kind      = kind_t'(m_tuser);
                got.slot      = m_tdata[SLOT_W-1:0];
                got.seg_start = m_tdata[START_LSB +: OFF_W];
                got.seg_end   = m_tdata[END_LSB +: OFF_W];
                got.last      = m_tlast;
                got.accepted  = m_tdata[ACC_BIT];
                got.done_res  = m_tdata[DONE_BIT];
                if (expected_segs.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected beat: expected none, ", $time,
                             "got kind %0d slot %0d [%h,%h) last %b acc %b done %b",
                             got.kind, got.slot, got.seg_start, got.seg_end,
                             got.last, got.accepted, got.done_res);
                end
                else
                begin
                    want = expected_segs.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: beat mismatch: ", $time,
                                 "expected kind %0d slot %0d [%h,%h) last %b acc %b done %b, ",
                                 want.kind, want.slot, want.seg_start, want.seg_end,
                                 want.last, want.accepted, want.done_res,
                                 "got kind %0d slot %0d [%h,%h) last %b acc %b done %b",
                                 got.kind, got.slot, got.seg_start, got.seg_end,
                                 got.last, got.accepted, got.done_res);
                    end
                end
            end
            pending <= expected_segs.size();
        end
    end

endmodule

// File: verif/sliding_window_arq_sender_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the ARQ sender core: clock, reset, event stimulus, sink and verdict.
module sliding_window_arq_sender_core_tb;
    import swarq_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 40;
    localparam int END_LSB       = SLOT_W + OFF_W;
    localparam int ACC_BIT       = SLOT_W + 2 * OFF_W;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
    localparam logic [OFF_W-1:0]     OFF_MAX     = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [OFF_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // chunk_bytes, ack_offset, zero pad
    logic [FUNC_W-1:0]    s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // slot, seg_start, seg_end, accepted, done_res, pad
    logic [KIND_W-1:0]    m_tuser;   // kind
    logic                 m_tlast;

    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    bit               no_idle = 0;
    bit               hold_sink = 0;
    logic [OFF_W-1:0] chunk_ends[$];
    logic [OFF_W-1:0] ack_high = '0;
    logic [LIMIT_W-1:0] phase_limits [5] = '{5'd1, 5'd16, 5'd5, 5'd31, 5'd8};

    sliding_window_arq_sender_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    arq_window_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // segment ends seen on stored chunks, used to aim acks
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready && m_tdata[ACC_BIT])
        begin
            chunk_ends.push_back(m_tdata[END_LSB +: OFF_W]);
            if (chunk_ends.size() > 24)
                void'(chunk_ends.pop_front());
        end
    end

    // result sink
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (hold_sink)
            begin
                hold_sink = 0;
                gap = HOLD_CYCLES;
            end
            repeat (gap)
            begin
                @(negedge clk);
                m_tready = 1'b0;
            end
            @(negedge clk);
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic offer(func_t fn, logic [BYTES_W-1:0] nbytes, logic [OFF_W-1:0] ack);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = S_TDATA_W'({ack, nbytes});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (fn == FN_ACK && ack > ack_high)
            ack_high = ack;
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFF_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [OFF_W-1:0] pick_ack();
        int r;
        r = $urandom_range(0, 99);
        if (chunk_ends.size() > 0 && r < 35)
            return chunk_ends[$urandom_range(0, chunk_ends.size() - 1)];
        if (r < 60)
            return ack_high;
        if (r < 70)
            return (ack_high > 64) ? ack_high - $urandom_range(1, 64) : '0;
        if (r < 90 || chunk_ends.size() == 0)
            return ack_high + $urandom_range(0, 2047);
        return chunk_ends[$urandom_range(0, chunk_ends.size() - 1)] + $urandom_range(0, 1023);
    endfunction

    task automatic random_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            offer(FN_CHUNK, ($urandom_range(0, 9) == 0) ? BYTES_W'($urandom_range(1025, 2047))
                                                       : BYTES_W'($urandom_range(0, 1024)),
                  $urandom);
        else if (r < 58)
            offer(FN_SEND, BYTES_W'($urandom), $urandom);
        else if (r < 85)
            offer(FN_ACK, BYTES_W'($urandom), pick_ack());
        else
        begin
            offer(FN_TICK, BYTES_W'($urandom), $urandom);
            if ($urandom_range(0, 1))
                offer(FN_TICK, BYTES_W'($urandom), $urandom);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FN_CHUNK;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_TOTAL_LENGTH, OFF_MAX);
        write_reg(REG_SEND_LIMIT, '0);
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, 32'h5A5A_0003);

        // limit zero: nothing goes out; empty-ring tick; early duplicate ack
        offer(FN_SEND,  '0, '0);
        offer(FN_TICK,  '0, '0);
        offer(FN_ACK,   '0, '0);
        offer(FN_CHUNK, '0, '0);
        offer(FN_CHUNK, '1, '0);
        offer(FN_CHUNK, BYTES_W'(CHUNK_MAX), '0);
        offer(FN_CHUNK, BYTES_W'(1), '0);
        offer(FN_SEND,  '0, '0);
        settle();
        write_reg(REG_SEND_LIMIT, 5'd31);

        // sends, stalled ticks, fast retransmit, slides, stale ack
        offer(FN_SEND, '0, '0);
        offer(FN_SEND, '0, '0);
        offer(FN_SEND, '0, '0);
        offer(FN_TICK, '0, '0);
        offer(FN_TICK, '0, '0);
        offer(FN_ACK,  '0, '0);
        offer(FN_SEND, '0, '0);
        offer(FN_ACK,  '0, 32'd1024);
        offer(FN_ACK,  '0, 32'd1024);
        offer(FN_ACK,  '0, 32'd5);
        offer(FN_SEND, '0, '0);
        offer(FN_SEND, '0, '0);
        offer(FN_ACK,  '0, 32'd2049);
        offer(FN_ACK,  '0, 32'd2049);
        offer(FN_SEND, '0, '0);

        for (int p = 0; p < 5; p++)
        begin
            settle();
            write_reg(REG_SEND_LIMIT, phase_limits[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 16 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (p == 1 && i == 20)
                    hold_sink = 1;
                random_event();
            end
        end

        // high ack offsets, then the end of the transfer
        settle();
        no_idle = 0;
        write_reg(REG_TOTAL_LENGTH, OFF_MAX);
        offer(FN_ACK,   '0, 32'hFFFF_FFFE);
        offer(FN_CHUNK, BYTES_W'(CHUNK_MAX), '0);
        offer(FN_SEND,  '0, '0);
        offer(FN_TICK,  '0, '0);
        offer(FN_TICK,  '0, '0);
        offer(FN_ACK,   '0, 32'hAAAA_AAAA);
        offer(FN_ACK,   '0, 32'h5555_5555);
        settle();
        write_reg(REG_TOTAL_LENGTH, '0);
        offer(FN_ACK,   '0, '0);
        offer(FN_CHUNK, BYTES_W'(7), '0);
        offer(FN_SEND,  '0, '0);
        offer(FN_TICK,  '0, '0);
        offer(FN_ACK,   '0, 32'd3);
        settle();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
